// ===== design/lrbs_pkg.sv =====
// Shared types and constants for the link reconnect backoff supervisor.
package lrbs_pkg;

  typedef enum logic [2:0] {
    MODE_BOOT       = 3'd0,
    MODE_CONNECTING = 3'd1,
    MODE_CONNECTED  = 3'd2,
    MODE_BACKOFF    = 3'd3,
    MODE_FAILED     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    OP_CHECK      = 2'd0,
    OP_ADDR       = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_START      = 2'd3
  } op_t;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgAddrW-1:0] CFG_CONNECT_TIMEOUT = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_MAX_ATTEMPTS    = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_BACKOFF_BASE    = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_BACKOFF_MAX     = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_LINK_LOST       = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_FAIL_HOLD       = 3'd5;

  localparam logic [23:0] RST_CONNECT_TIMEOUT = 24'd15000;
  localparam logic [7:0]  RST_MAX_ATTEMPTS    = 8'd10;
  localparam logic [23:0] RST_BACKOFF_BASE    = 24'd1000;
  localparam logic [23:0] RST_BACKOFF_MAX     = 24'd60000;
  localparam logic [23:0] RST_LINK_LOST       = 24'd3000;
  localparam logic [23:0] RST_FAIL_HOLD       = 24'd3000;

  typedef struct packed {
    logic [23:0] connect_timeout_ms;
    logic [7:0]  max_attempts;
    logic [23:0] backoff_base_ms;
    logic [23:0] backoff_max_ms;
    logic [23:0] link_lost_ms;
    logic [23:0] fail_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic        link_up;
    logic        provisioning;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        connect_request;
    logic        dhcp_restart;
    logic        reboot_request;
    logic        link_ok;
    logic [7:0]  attempt_count;
    logic [23:0] backoff_ms;
  } out_item_t;

endpackage

// ===== design/lrbs_backoff.sv =====
// Backoff delay: base shifted by attempt index, saturated at the ceiling.
module lrbs_backoff (
  input  logic [7:0]  shift,
  input  logic [23:0] base_ms,
  input  logic [23:0] max_ms,
  output logic [23:0] delay_ms
);
  import lrbs_pkg::*;

  localparam int unsigned ValW = 24;
  localparam int unsigned ShW  = $clog2(ValW);

  logic [2*ValW-1:0] shifted;

  assign shifted = {{ValW{1'b0}}, base_ms} << shift[ShW-1:0];

  always_comb begin
    if (base_ms == '0) begin
      delay_ms = '0;
    end else if (shift >= 8'(ValW)) begin
      // any nonzero base shifted this far exceeds every 24-bit ceiling
      delay_ms = max_ms;
    end else if (shifted > {{ValW{1'b0}}, max_ms}) begin
      delay_ms = max_ms;
    end else begin
      delay_ms = shifted[ValW-1:0];
    end
  end

endmodule

// ===== design/lrbs_core.sv =====
// Supervisor state registers and per-item update logic.
module lrbs_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lrbs_pkg::in_item_t  item,
  input  lrbs_pkg::cfg_t      cfg,
  output lrbs_pkg::out_item_t result
);
  import lrbs_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [23:0] backoff_r, backoff_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [1:0]  dhcp_cnt_r, dhcp_cnt_nxt;
  logic        link_ok_r, link_ok_nxt;

  logic [31:0] elapsed;
  logic        timeout, lost, chk;
  logic        start_go, addr_go, disc_go, conn_dhcp, conn_fail, bo_go, reboot;
  logic [7:0]  attempts_inc;
  logic        fail_hit;
  logic [23:0] backoff_calc;

  assign elapsed      = item.now_ms - entry_r;
  assign timeout      = elapsed >= {8'b0, cfg.connect_timeout_ms};
  assign lost         = elapsed > {8'b0, cfg.link_lost_ms};
  assign attempts_inc = (attempts_r == 8'hFF) ? attempts_r : attempts_r + 8'd1;
  assign fail_hit     = attempts_inc >= cfg.max_attempts;

  assign chk       = (op_t'(item.op) == OP_CHECK) && !item.provisioning;
  assign start_go  = (op_t'(item.op) == OP_START) && (mode_r == MODE_BOOT);
  assign addr_go   = (op_t'(item.op) == OP_ADDR);
  assign disc_go   = (op_t'(item.op) == OP_DISCONNECT) && !item.provisioning &&
                     (mode_r == MODE_CONNECTED);
  assign conn_dhcp = chk && (mode_r == MODE_CONNECTING) && item.link_up && timeout;
  assign conn_fail = chk && (mode_r == MODE_CONNECTING) && !item.link_up &&
                     (timeout || lost);
  assign bo_go     = chk && (mode_r == MODE_BACKOFF) &&
                     (elapsed >= {8'b0, backoff_r});
  assign reboot    = chk && (mode_r == MODE_FAILED) &&
                     (elapsed >= {8'b0, cfg.fail_hold_ms});

  lrbs_backoff u_backoff (
    .shift    (attempts_inc - 8'd1),
    .base_ms  (cfg.backoff_base_ms),
    .max_ms   (cfg.backoff_max_ms),
    .delay_ms (backoff_calc)
  );

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    unique case (op_t'(item.op))
      OP_START:      if (start_go) mode_nxt = MODE_CONNECTING;
      OP_ADDR:       mode_nxt = MODE_CONNECTED;
      OP_DISCONNECT: if (disc_go) mode_nxt = MODE_CONNECTING;
      OP_CHECK: begin
        if (conn_fail) begin
          mode_nxt = fail_hit ? MODE_FAILED : MODE_BACKOFF;
        end else if (bo_go) begin
          mode_nxt = MODE_CONNECTING;
        end
      end
      default: mode_nxt = mode_r;
    endcase
  end

  // data registers and pulses
  always_comb begin
    attempts_nxt = attempts_r;
    backoff_nxt  = backoff_r;
    entry_nxt    = entry_r;
    dhcp_cnt_nxt = dhcp_cnt_r;
    link_ok_nxt  = link_ok_r;

    if (start_go || addr_go || disc_go || conn_fail || bo_go || conn_dhcp ||
        ((op_t'(item.op) == OP_CHECK) && item.provisioning)) begin
      entry_nxt = item.now_ms;
    end
    if (addr_go) begin
      attempts_nxt = '0;
      backoff_nxt  = '0;
      dhcp_cnt_nxt = '0;
      link_ok_nxt  = 1'b1;
    end
    if (op_t'(item.op) == OP_DISCONNECT) begin
      link_ok_nxt = 1'b0;
    end
    if (disc_go) begin
      attempts_nxt = '0;
    end
    if (conn_dhcp && (dhcp_cnt_r != 2'd2)) begin
      dhcp_cnt_nxt = dhcp_cnt_r + 2'd1;
    end
    if (conn_fail) begin
      dhcp_cnt_nxt = '0;
      attempts_nxt = attempts_inc;
      if (fail_hit) begin
        link_ok_nxt = 1'b0;
      end else begin
        backoff_nxt = backoff_calc;
      end
    end

    result.mode            = mode_nxt;
    result.connect_request = start_go || disc_go || bo_go;
    // restart only on the first timeout seen with the link up
    result.dhcp_restart    = conn_dhcp && (dhcp_cnt_r == 2'd0);
    result.reboot_request  = reboot;
    result.link_ok         = link_ok_nxt;
    result.attempt_count   = attempts_nxt;
    result.backoff_ms      = backoff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BOOT;
      attempts_r <= '0;
      backoff_r  <= '0;
      entry_r    <= '0;
      dhcp_cnt_r <= '0;
      link_ok_r  <= 1'b0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      attempts_r <= attempts_nxt;
      backoff_r  <= backoff_nxt;
      entry_r    <= entry_nxt;
      dhcp_cnt_r <= dhcp_cnt_nxt;
      link_ok_r  <= link_ok_nxt;
    end
  end

endmodule

// ===== design/link_reconnect_backoff_supervisor_unit.sv =====
// Link reconnect supervisor: input stage, config registers, result register.
// The input register captures each accepted item, then the result register captures the
// core's result and raises out_valid, which holds until out_ready takes the result.
// Throughput: one item per cycle unless out_ready stalls; state update: one core-logic pass.
// Reset (rst_n low, synchronous): supervisor state to boot and zero, config
// registers to their defaults, both stages empty.
module link_reconnect_backoff_supervisor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lrbs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lrbs_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lrbs_pkg::CfgAddrW-1:0]       cfg_addr,
  input  logic [lrbs_pkg::CfgDataW-1:0]       cfg_wdata
);
  import lrbs_pkg::*;

  cfg_t      cfg_r;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      step;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout_ms <= RST_CONNECT_TIMEOUT;
      cfg_r.max_attempts       <= RST_MAX_ATTEMPTS;
      cfg_r.backoff_base_ms    <= RST_BACKOFF_BASE;
      cfg_r.backoff_max_ms     <= RST_BACKOFF_MAX;
      cfg_r.link_lost_ms       <= RST_LINK_LOST;
      cfg_r.fail_hold_ms       <= RST_FAIL_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CONNECT_TIMEOUT: cfg_r.connect_timeout_ms <= cfg_wdata;
        CFG_MAX_ATTEMPTS:    cfg_r.max_attempts       <= cfg_wdata[7:0];
        CFG_BACKOFF_BASE:    cfg_r.backoff_base_ms    <= cfg_wdata;
        CFG_BACKOFF_MAX:     cfg_r.backoff_max_ms     <= cfg_wdata;
        CFG_LINK_LOST:       cfg_r.link_lost_ms       <= cfg_wdata;
        CFG_FAIL_HOLD:       cfg_r.fail_hold_ms       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  lrbs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_data_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the link reconnect backoff supervisor unit.
module tb;
  import lrbs_pkg::*;

  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned QuietTail      = 150;
  localparam int unsigned MaxReports     = 50;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t result;
  } dir_row_t;

  typedef struct {
    cfg_t        regs;
    int unsigned items;
    int unsigned step_max;
    int unsigned link_pct;
    int unsigned addr_pct;
    int unsigned disc_pct;
  } phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  // typed-in expectation riding along with the current transfer
  logic      pin_en;
  out_item_t pin_result;

  // supervisor shadow state
  cfg_t        cfg_shadow;
  mode_t       sup_mode;
  logic [7:0]  sup_attempts;
  logic [23:0] sup_backoff;
  logic [31:0] sup_entry;
  logic [1:0]  sup_dhcp_wait;
  logic        sup_link_ok;

  out_item_t   expected_results[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  logic [31:0] clock_ms;
  bit          long_hold;
  bit          quiet;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;

  link_reconnect_backoff_supervisor_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [23:0] backoff_delay(logic [7:0] shift);
    logic [63:0] wide;
    if (cfg_shadow.backoff_base_ms == '0) return '0;
    if (shift >= 8'd32) return cfg_shadow.backoff_max_ms;
    wide = 64'(cfg_shadow.backoff_base_ms) << shift;
    if (wide > 64'(cfg_shadow.backoff_max_ms)) return cfg_shadow.backoff_max_ms;
    return wide[23:0];
  endfunction

  function automatic void enter_mode(mode_t m, logic [31:0] now);
    sup_mode  = m;
    sup_entry = now;
    if (m == MODE_CONNECTED) begin
      sup_link_ok = 1'b1;
    end else if (m == MODE_FAILED) begin
      sup_link_ok = 1'b0;
    end
  endfunction

  function automatic out_item_t supervise_step(in_item_t it);
    out_item_t   res;
    logic [31:0] elapsed;
    logic        conn_expired;
    res          = '0;
    elapsed      = it.now_ms - sup_entry;
    conn_expired = elapsed >= 32'(cfg_shadow.connect_timeout_ms);
    case (op_t'(it.op))
      OP_START: begin
        if (sup_mode == MODE_BOOT) begin
          res.connect_request = 1'b1;
          enter_mode(MODE_CONNECTING, it.now_ms);
        end
      end
      OP_ADDR: begin
        sup_attempts  = '0;
        sup_backoff   = '0;
        sup_dhcp_wait = '0;
        enter_mode(MODE_CONNECTED, it.now_ms);
      end
      OP_DISCONNECT: begin
        sup_link_ok = 1'b0;
        if (!it.provisioning && sup_mode == MODE_CONNECTED) begin
          sup_attempts        = '0;
          res.connect_request = 1'b1;
          enter_mode(MODE_CONNECTING, it.now_ms);
        end
      end
      OP_CHECK: begin
        if (it.provisioning) begin
          sup_entry = it.now_ms;
        end else begin
          case (sup_mode)
            MODE_CONNECTING: begin
              if (it.link_up && conn_expired) begin
                // associated but no address yet: nudge the address client once
                if (sup_dhcp_wait < 2'd2) sup_dhcp_wait = sup_dhcp_wait + 2'd1;
                res.dhcp_restart = (sup_dhcp_wait == 2'd1);
                sup_entry        = it.now_ms;
              end else if (!it.link_up &&
                           (conn_expired || elapsed > 32'(cfg_shadow.link_lost_ms))) begin
                sup_dhcp_wait = '0;
                if (sup_attempts != 8'hFF) sup_attempts = sup_attempts + 8'd1;
                if (sup_attempts >= cfg_shadow.max_attempts) begin
                  enter_mode(MODE_FAILED, it.now_ms);
                end else begin
                  sup_backoff = backoff_delay(sup_attempts - 8'd1);
                  enter_mode(MODE_BACKOFF, it.now_ms);
                end
              end
            end
            MODE_BACKOFF: begin
              if (elapsed >= 32'(sup_backoff)) begin
                res.connect_request = 1'b1;
                enter_mode(MODE_CONNECTING, it.now_ms);
              end
            end
            MODE_FAILED: begin
              res.reboot_request = elapsed >= 32'(cfg_shadow.fail_hold_ms);
            end
            default: ;
          endcase
        end
      end
    endcase
    res.mode          = sup_mode;
    res.link_ok       = sup_link_ok;
    res.attempt_count = sup_attempts;
    res.backoff_ms    = sup_backoff;
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endfunction

  // prediction on every accepted input transfer
  always @(posedge clk) begin : input_monitor
    out_item_t predicted;
    if (rst_n && in_valid && in_ready) begin
      predicted = supervise_step(in_data);
      expected_results.push_back(pin_en ? pin_result : predicted);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("%0t: result expected none actual %p", $time, out_data);
        end
      end else begin
        want = expected_results.pop_front();
        compare_field("mode", 32'(want.mode), 32'(out_data.mode));
        compare_field("connect_request", 32'(want.connect_request),
                      32'(out_data.connect_request));
        compare_field("dhcp_restart", 32'(want.dhcp_restart), 32'(out_data.dhcp_restart));
        compare_field("reboot_request", 32'(want.reboot_request),
                      32'(out_data.reboot_request));
        compare_field("link_ok", 32'(want.link_ok), 32'(out_data.link_ok));
        compare_field("attempt_count", 32'(want.attempt_count), 32'(out_data.attempt_count));
        compare_field("backoff_ms", 32'(want.backoff_ms), 32'(out_data.backoff_ms));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        // long back-pressure so the block fills and stalls its input
        out_ready <= 1'b0;
        for (held = 0; held < LongHoldCycles; held++) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic cfg_t mk_cfg(logic [23:0] timeout, logic [7:0] attempts,
                                  logic [23:0] base, logic [23:0] ceiling,
                                  logic [23:0] lost, logic [23:0] hold);
    cfg_t c;
    c.connect_timeout_ms = timeout;
    c.max_attempts       = attempts;
    c.backoff_base_ms    = base;
    c.backoff_max_ms     = ceiling;
    c.link_lost_ms       = lost;
    c.fail_hold_ms       = hold;
    return c;
  endfunction

  function automatic phase_t mk_phase(cfg_t regs, int unsigned items, int unsigned step_max,
                                      int unsigned link_pct, int unsigned addr_pct,
                                      int unsigned disc_pct);
    phase_t ph;
    ph.regs     = regs;
    ph.items    = items;
    ph.step_max = step_max;
    ph.link_pct = link_pct;
    ph.addr_pct = addr_pct;
    ph.disc_pct = disc_pct;
    return ph;
  endfunction

  function automatic in_item_t mk_event(op_t op, logic [31:0] now, bit link_up, bit prov);
    in_item_t it;
    it.op           = op;
    it.now_ms       = now;
    it.link_up      = link_up;
    it.provisioning = prov;
    return it;
  endfunction

  function automatic dir_row_t mk_row(op_t op, logic [31:0] now, bit link_up, bit prov,
                                      bit pinned = 1'b0, out_item_t result = '0);
    dir_row_t row;
    row.item   = mk_event(op, now, link_up, prov);
    row.pinned = pinned;
    row.result = result;
    return row;
  endfunction

  function automatic out_item_t mk_result(mode_t m, bit req, bit dhcp, bit reboot, bit ok,
                                          logic [7:0] attempts, logic [23:0] backoff);
    out_item_t r;
    r.mode            = m;
    r.connect_request = req;
    r.dhcp_restart    = dhcp;
    r.reboot_request  = reboot;
    r.link_ok         = ok;
    r.attempt_count   = attempts;
    r.backoff_ms      = backoff;
    return r;
  endfunction

  // mostly monotonic time with small steps, now and then a jump anywhere
  function automatic in_item_t next_event(phase_t ph);
    int unsigned r;
    op_t         op;
    r = $urandom_range(0, 99);
    if (r < ph.addr_pct) op = OP_ADDR;
    else if (r < ph.addr_pct + ph.disc_pct) op = OP_DISCONNECT;
    else if (r < ph.addr_pct + ph.disc_pct + 3) op = OP_START;
    else op = OP_CHECK;
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, ph.step_max);
    return mk_event(op, clock_ms, $urandom_range(0, 99) < ph.link_pct,
                    $urandom_range(0, 99) < 5);
  endfunction

  // called right after a falling edge; returns on the falling edge after the transfer
  task automatic push_item(in_item_t it, bit pinned, out_item_t result);
    if (!quiet && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= it;
    pin_en     <= pinned;
    pin_result <= result;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  // registers change only with the pipeline drained
  task automatic apply_cfg(cfg_t c);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_CONNECT_TIMEOUT, c.connect_timeout_ms);
    write_reg(CFG_MAX_ATTEMPTS, {16'd0, c.max_attempts});
    write_reg(CFG_BACKOFF_BASE, c.backoff_base_ms);
    write_reg(CFG_BACKOFF_MAX, c.backoff_max_ms);
    write_reg(CFG_LINK_LOST, c.link_lost_ms);
    write_reg(CFG_FAIL_HOLD, c.fail_hold_ms);
    cfg_we     <= 1'b0;
    cfg_shadow = c;
  endtask

  initial begin : stimulus
    dir_row_t    rows[$];
    phase_t      phases[$];
    int unsigned n;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    pin_en         = 1'b0;
    pin_result     = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    long_hold      = 1'b0;
    quiet          = 1'b0;
    tx_gap_pct     = 25;
    rx_stall_pct   = 25;
    clock_ms       = '0;
    cfg_shadow     = mk_cfg(RST_CONNECT_TIMEOUT, RST_MAX_ATTEMPTS, RST_BACKOFF_BASE,
                            RST_BACKOFF_MAX, RST_LINK_LOST, RST_FAIL_HOLD);
    sup_mode       = MODE_BOOT;
    sup_attempts   = '0;
    sup_backoff    = '0;
    sup_entry      = '0;
    sup_dhcp_wait  = '0;
    sup_link_ok    = 1'b0;

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // short attempt budget and a low ceiling so the directed walk reaches failed
    apply_cfg(mk_cfg(RST_CONNECT_TIMEOUT, 8'd4, RST_BACKOFF_BASE, 24'd3000,
                     RST_LINK_LOST, RST_FAIL_HOLD));

    rows.push_back(mk_row(OP_CHECK, 32'd0, 1'b0, 1'b0, 1'b1,
                          mk_result(MODE_BOOT, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0)));
    rows.push_back(mk_row(OP_START, 32'd100, 1'b0, 1'b1, 1'b1,
                          mk_result(MODE_CONNECTING, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0)));
    rows.push_back(mk_row(OP_START, 32'd200, 1'b0, 1'b0, 1'b1,
                          mk_result(MODE_CONNECTING, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0)));
    rows.push_back(mk_row(OP_CHECK, 32'd5000, 1'b0, 1'b1));   // provisioning re-arms timer
    rows.push_back(mk_row(OP_CHECK, 32'd20000, 1'b1, 1'b0));  // link up at timeout
    rows.push_back(mk_row(OP_CHECK, 32'd35000, 1'b1, 1'b0));  // second time, no pulse
    rows.push_back(mk_row(OP_CHECK, 32'd38001, 1'b0, 1'b0));  // link lost
    rows.push_back(mk_row(OP_CHECK, 32'd38999, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'd39001, 1'b0, 1'b0));  // backoff expiry
    rows.push_back(mk_row(OP_CHECK, 32'd42001, 1'b0, 1'b0));  // exactly at link-lost time
    rows.push_back(mk_row(OP_CHECK, 32'd42002, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'd44002, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'd47003, 1'b0, 1'b0));  // backoff hits ceiling
    rows.push_back(mk_row(OP_CHECK, 32'd50003, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_DISCONNECT, 32'd50010, 1'b1, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'd53004, 1'b0, 1'b0));  // attempt budget spent
    rows.push_back(mk_row(OP_CHECK, 32'd56003, 1'b1, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'd56004, 1'b0, 1'b0));  // reboot request
    rows.push_back(mk_row(OP_START, 32'd56005, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_ADDR, 32'd56010, 1'b0, 1'b1, 1'b1,
                          mk_result(MODE_CONNECTED, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 24'd0)));
    rows.push_back(mk_row(OP_CHECK, 32'd56020, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_DISCONNECT, 32'd56030, 1'b0, 1'b1));
    rows.push_back(mk_row(OP_ADDR, 32'd56040, 1'b1, 1'b0));
    rows.push_back(mk_row(OP_DISCONNECT, 32'hFFFF_FF00, 1'b0, 1'b0));
    rows.push_back(mk_row(OP_CHECK, 32'h0000_0BB9, 1'b0, 1'b0)); // timestamp wrap
    foreach (rows[i]) push_item(rows[i].item, rows[i].pinned, rows[i].result);

    phases.push_back(mk_phase(mk_cfg(24'd200, 8'd5, 24'd10, 24'd100, 24'd50, 24'd30),
                              300, 120, 40, 5, 6));
    // long attempt run up to count saturation
    phases.push_back(mk_phase(mk_cfg(24'd20, 8'd255, 24'd1, 24'd8, 24'd5, 24'd0),
                              800, 30, 10, 0, 2));
    phases.push_back(mk_phase(mk_cfg(24'd0, 8'd0, 24'd0, 24'd0, 24'd0, 24'd0),
                              150, 5, 50, 10, 8));
    phases.push_back(mk_phase(mk_cfg(24'hFFFFFF, 8'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                     24'hFFFFFF), 200, 32'h0100_0000, 30, 10, 6));
    phases.push_back(mk_phase(mk_cfg(RST_CONNECT_TIMEOUT, RST_MAX_ATTEMPTS, RST_BACKOFF_BASE,
                                     RST_BACKOFF_MAX, RST_LINK_LOST, RST_FAIL_HOLD),
                              350, 4000, 50, 5, 6));

    foreach (phases[p]) begin
      apply_cfg(phases[p].regs);
      clock_ms = $urandom();
      // recover to connected, then drop the link to open a fresh connect
      push_item(mk_event(OP_ADDR, clock_ms, 1'b0, 1'b0), 1'b0, '0);
      push_item(mk_event(OP_DISCONNECT, clock_ms, 1'b0, 1'b0), 1'b0, '0);
      for (n = 0; n < phases[p].items; n++) begin
        if (n % 64 == 0) begin
          tx_gap_pct   = 25 * $urandom_range(0, 2);
          rx_stall_pct = 25 * $urandom_range(0, 2);
        end
        if (p == 0 && n == 40) long_hold = 1'b1;
        if (p == phases.size() - 1 && n + QuietTail >= phases[p].items) quiet = 1'b1;
        push_item(next_event(phases[p]), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
